### src/ouart_pkg.sv
// ouart_pkg: shared types and constants for the oversampled uart with receive fifo
// no dependencies; imported by the receiver, fifo, transmitter and top level
package ouart_pkg;

	localparam int DATA_BITS = 8;

	// receiver sequence: wait for low level, recheck, data bits, stop point
	typedef enum logic [1:0] {
		RX_IDLE,
		RX_CHECK,
		RX_DATA,
		RX_STOP
	} rx_phase_t;

	// byte handed from the receiver to the fifo at the stop point
	typedef struct packed {
		logic                 done;
		logic [DATA_BITS-1:0] data;
	} rx_frame_t;

endpackage

### src/ouart_rx.sv
// ouart_rx: oversampled receiver, start check and lsb-first data sampling
// depends on ouart_pkg for the phase enum and the frame struct
module ouart_rx import ouart_pkg::*; #(
	parameter int TICKS_PER_BIT = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      level,
	output rx_frame_t frame
);

	localparam int WW = $clog2(TICKS_PER_BIT + 1);
	localparam int CW = $clog2(DATA_BITS);
	localparam logic [WW-1:0] WAIT_ONE  = WW'(1);
	localparam logic [WW-1:0] WAIT_HALF = WW'(TICKS_PER_BIT / 2);
	localparam logic [WW-1:0] WAIT_BIT  = WW'(TICKS_PER_BIT);
	localparam logic [CW-1:0] LAST_BIT  = CW'(DATA_BITS - 1);

	rx_phase_t            phase_q, phase_d;
	logic [WW-1:0]        wait_q, wait_d;
	logic [CW-1:0]        bit_q, bit_d;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic                 expire;

	// a zero count is taken as expiring too
	assign expire = (wait_q <= WAIT_ONE);

	always_comb begin
		phase_d = phase_q;
		if (expire) begin
			case (phase_q)
				RX_IDLE: begin
					if (!level)
						phase_d = RX_CHECK;
				end
				RX_CHECK: begin
					phase_d = level ? RX_IDLE : RX_DATA;
				end
				RX_DATA: begin
					if (bit_q == LAST_BIT)
						phase_d = RX_STOP;
				end
				RX_STOP: begin
					phase_d = RX_IDLE;
				end
				default: begin
					phase_d = RX_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		wait_d     = expire ? WAIT_ONE : wait_q - WAIT_ONE;
		bit_d      = bit_q;
		shift_d    = shift_q;
		frame.done = 1'b0;
		frame.data = shift_q;
		if (expire) begin
			case (phase_q)
				RX_IDLE: begin
					if (!level)
						wait_d = WAIT_HALF;
				end
				RX_CHECK: begin
					if (!level) begin
						wait_d = WAIT_BIT;
						bit_d  = '0;
					end
				end
				RX_DATA: begin
					shift_d = {level, shift_q[DATA_BITS-1:1]};
					wait_d  = WAIT_BIT;
					bit_d   = bit_q + CW'(1);
				end
				RX_STOP: begin
					frame.done = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= RX_IDLE;
			wait_q  <= WAIT_ONE;
			bit_q   <= '0;
			shift_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			wait_q  <= wait_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
		end
	end

`ifndef ASSERT_OFF
	a_wait_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q != '0)
		else $error("receiver wait count reached zero");
	a_stop_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		en && frame.done |=> phase_q == RX_IDLE)
		else $error("receiver did not return to idle after the stop point");
`endif

endmodule

### src/ouart_fifo.sv
// ouart_fifo: receive fifo with push-before-pop ordering and overrun flag
// depends on ouart_pkg for the frame struct
module ouart_fifo import ouart_pkg::*; #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  rx_frame_t                        frame,
	input  logic                             pop,
	output logic [DATA_BITS-1:0]             rx_data,
	output logic                             rx_data_valid,
	output logic [$clog2(FIFO_DEPTH+1)-1:0]  rx_count,
	output logic                             rx_overrun
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [FW-1:0] FILL_MAX = FW'(FIFO_DEPTH);

	logic [DATA_BITS-1:0] mem_q [FIFO_DEPTH];
	logic [DATA_BITS-1:0] data_q;
	logic [PW-1:0]        wr_q, rd_q;
	logic [FW-1:0]        fill_q, fill_d;
	logic                 valid_q, overrun_q;
	logic                 full, push, drop, pop_ok, bypass;

	assign full   = (fill_q == FILL_MAX);
	assign push   = en && frame.done && !full;
	assign drop   = en && frame.done && full;
	assign pop_ok = en && pop && (fill_q != '0 || push);
	// pop on an empty fifo takes the byte pushed on the same tick
	assign bypass = push && (fill_q == '0);

	always_comb begin
		case ({push, pop_ok})
			2'b10:   fill_d = fill_q + FW'(1);
			2'b01:   fill_d = fill_q - FW'(1);
			default: fill_d = fill_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= frame.data;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pop_ok)
				data_q <= bypass ? frame.data : mem_q[rd_q];
			else
				data_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q      <= '0;
			rd_q      <= '0;
			fill_q    <= '0;
			valid_q   <= 1'b0;
			overrun_q <= 1'b0;
		end else if (en) begin
			if (push)
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			if (pop_ok)
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			fill_q    <= fill_d;
			valid_q   <= pop_ok;
			overrun_q <= drop;
		end
	end

	assign rx_data       = data_q;
	assign rx_data_valid = valid_q;
	assign rx_count      = fill_q;
	assign rx_overrun    = overrun_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fifo fill count above depth");
	a_ptr_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_q == wr_q) |-> (fill_q == '0 || full))
		else $error("fifo pointers disagree with fill count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(fill_q) && $stable(rd_q) && $stable(wr_q))
		else $error("fifo state moved without a tick");
`endif

endmodule

### src/ouart_tx.sv
// ouart_tx: transmitter, start bit, lsb-first data and stop bits per frame
// depends on ouart_pkg for the data width
module ouart_tx import ouart_pkg::*; #(
	parameter int TICKS_PER_BIT = 4,
	parameter int TX_FRAME_BITS = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 load,
	input  logic [DATA_BITS-1:0] tx_byte,
	output logic                 tx_line,
	output logic                 tx_busy
);

	localparam int BW = $clog2(TX_FRAME_BITS + 1);
	localparam int SW = $clog2(TICKS_PER_BIT);
	localparam logic [BW-1:0] FRAME_LEN = BW'(TX_FRAME_BITS);
	localparam logic [SW-1:0] SUB_LAST  = SW'(TICKS_PER_BIT - 1);

	// remaining ticks = bits_q * TICKS_PER_BIT + sub_q
	logic [BW-1:0]        bits_q, bits_d;
	logic [SW-1:0]        sub_q, sub_d;
	logic [DATA_BITS-1:0] shift_q, shift_d;
	logic                 next_q, next_d;
	logic                 line_q, line_d;
	logic                 busy, busy_after;

	assign busy = (bits_q != '0) || (sub_q != '0);

	always_comb begin
		bits_d  = bits_q;
		sub_d   = sub_q;
		shift_d = shift_q;
		next_d  = next_q;
		line_d  = line_q;
		if (busy) begin
			if (sub_q == '0) begin
				// bit boundary
				line_d  = next_q;
				next_d  = shift_q[0];
				shift_d = {1'b1, shift_q[DATA_BITS-1:1]};
				bits_d  = bits_q - BW'(1);
				sub_d   = SUB_LAST;
			end else begin
				sub_d = sub_q - SW'(1);
			end
		end
		busy_after = (bits_d != '0) || (sub_d != '0);
		if (load && !busy_after) begin
			next_d  = 1'b0;
			shift_d = tx_byte;
			bits_d  = FRAME_LEN;
			sub_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			sub_q   <= '0;
			shift_q <= '0;
			next_q  <= 1'b0;
			line_q  <= 1'b1;
		end else if (en) begin
			bits_q  <= bits_d;
			sub_q   <= sub_d;
			shift_q <= shift_d;
			next_q  <= next_d;
			line_q  <= line_d;
		end
	end

	assign tx_line = line_q;
	assign tx_busy = busy;

`ifndef ASSERT_OFF
	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> line_q)
		else $error("transmit line low while idle");
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q <= SUB_LAST && bits_q <= FRAME_LEN)
		else $error("transmit counters out of range");
`endif

endmodule

### src/oversampled_uart_with_rx_fifo.sv
// oversampled_uart_with_rx_fifo: one oversampling tick per transfer
// each input transfer is held in the input register, then its result is presented from the result register
// throughput: one tick per clock cycle while out_ready does not stall; the next input is taken while a result waits
// reset: receiver idle, transmit line high, fifo empty; fifo storage is not cleared
// depends on ouart_pkg, ouart_rx, ouart_fifo and ouart_tx
module oversampled_uart_with_rx_fifo import ouart_pkg::*; #(
	parameter int FIFO_DEPTH    = 16,
	parameter int TICKS_PER_BIT = 4,
	parameter int TX_FRAME_BITS = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             rx_level,
	input  logic                             tx_load,
	input  logic [DATA_BITS-1:0]             tx_byte,
	input  logic                             rx_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             tx_line,
	output logic [DATA_BITS-1:0]             rx_data,
	output logic                             rx_data_valid,
	output logic [$clog2(FIFO_DEPTH+1)-1:0]  rx_count,
	output logic                             tx_busy,
	output logic                             rx_overrun
);

	logic                 valid_s1, valid_s2, advance;
	logic                 rx_level_s1, tx_load_s1, rx_pop_s1;
	logic [DATA_BITS-1:0] tx_byte_s1;
	rx_frame_t            frame;

	// state in the submodules moves only when a tick goes to the result side
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_level_s1 <= rx_level;
			tx_load_s1  <= tx_load;
			tx_byte_s1  <= tx_byte;
			rx_pop_s1   <= rx_pop;
		end
	end

	ouart_rx #(
		.TICKS_PER_BIT(TICKS_PER_BIT)
	) u_rx (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.level (rx_level_s1),
		.frame (frame)
	);

	ouart_fifo #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.frame        (frame),
		.pop          (rx_pop_s1),
		.rx_data      (rx_data),
		.rx_data_valid(rx_data_valid),
		.rx_count     (rx_count),
		.rx_overrun   (rx_overrun)
	);

	ouart_tx #(
		.TICKS_PER_BIT(TICKS_PER_BIT),
		.TX_FRAME_BITS(TX_FRAME_BITS)
	) u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.load   (tx_load_s1),
		.tx_byte(tx_byte_s1),
		.tx_line(tx_line),
		.tx_busy(tx_busy)
	);

	assign out_valid = valid_s2;

`ifndef ASSERT_OFF
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("tick processed but no result presented");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(tx_byte_s1) && $stable(rx_pop_s1))
		else $error("input register lost a pending tick");
`endif

endmodule
